// File: rtl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int ADDR_BITS = 16;

    localparam logic [ADDR_BITS-1:0] HEAP_BEGIN_RST = 16'h8000;
    localparam logic [ADDR_BITS-1:0] HEAP_END_RST   = 16'hC000;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    localparam logic [3:0] OP_HOLD         = 4'd0;
    localparam logic [3:0] OP_INIT         = 4'd1;
    localparam logic [3:0] OP_START        = 4'd2;
    localparam logic [3:0] OP_STEP         = 4'd3;
    localparam logic [3:0] OP_SPLIT        = 4'd4;
    localparam logic [3:0] OP_SET_CUR      = 4'd5;
    localparam logic [3:0] OP_SET_CUR_SHL  = 4'd6;
    localparam logic [3:0] OP_SET_PREV_SHL = 4'd7;
    localparam logic [3:0] OP_SHL_GE       = 4'd8;

    typedef struct packed {
        logic [1:0]           action;
        logic [ADDR_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] result_address;
        logic [1:0]           status;
    } out_item_t;

    typedef struct packed {
        logic                 valid;
        logic                 free;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
    } entry_t;

    typedef struct packed {
        logic [3:0] op;
        entry_t     wr_a;
        entry_t     wr_b;
    } cell_cmd_t;

    typedef struct packed {
        logic   hit;
        entry_t prev;
        entry_t cur;
        entry_t next;
    } cell_rep_t;

endpackage

// File: rtl/ffha_cell.sv
// one table entry of the allocator chain with its scan token
module ffha_cell
    import ffha_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  entry_t    left_ent,
    input  logic      left_tok,
    input  entry_t    right_ent,
    input  logic      right_tok,
    output entry_t    ent,
    output logic      tok,
    output cell_rep_t rep
);

    entry_t ent_reg, ent_next;
    logic   tok_reg, tok_next;
    logic   seen_reg, seen_next;

    always_comb begin
        ent_next  = ent_reg;
        tok_next  = tok_reg;
        seen_next = seen_reg;
        unique case (cmd.op)
            OP_INIT: begin
                ent_next       = cmd.wr_a;
                ent_next.valid = IS_HEAD;
            end
            OP_START: begin
                tok_next  = IS_HEAD;
                seen_next = 1'b0;
            end
            OP_STEP: begin
                tok_next  = left_tok;
                seen_next = seen_reg | tok_reg;
            end
            OP_SPLIT: begin
                if (tok_reg) begin
                    ent_next = cmd.wr_a;
                end else if (left_tok) begin
                    ent_next = cmd.wr_b;
                end else if (!seen_reg) begin
                    ent_next = left_ent;
                end
            end
            OP_SET_CUR: begin
                if (tok_reg) begin
                    ent_next = cmd.wr_a;
                end
            end
            OP_SET_CUR_SHL: begin
                if (tok_reg) begin
                    ent_next = cmd.wr_a;
                end else if (!seen_reg) begin
                    ent_next = right_ent;
                end
            end
            OP_SET_PREV_SHL: begin
                if (right_tok) begin
                    ent_next = cmd.wr_a;
                end else if (tok_reg || !seen_reg) begin
                    ent_next = right_ent;
                end
            end
            OP_SHL_GE: begin
                if (tok_reg || !seen_reg) begin
                    ent_next = right_ent;
                end
            end
            default: begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= IS_HEAD;
            ent_reg.free  <= 1'b1;
            ent_reg.start <= HEAP_BEGIN_RST;
            ent_reg.size  <= HEAP_END_RST - HEAP_BEGIN_RST;
            tok_reg       <= 1'b0;
            seen_reg      <= 1'b0;
        end else begin
            ent_reg  <= ent_next;
            tok_reg  <= tok_next;
            seen_reg <= seen_next;
        end
    end

    assign ent = ent_reg;
    assign tok = tok_reg;

    always_comb begin
        rep = '0;
        if (tok_reg) begin
            rep.hit  = ent_reg.valid;
            rep.prev = left_ent;
            rep.cur  = ent_reg;
            rep.next = right_ent;
        end
    end

endmodule

// File: rtl/first_fit_heap_allocator_core.sv
// init and unused actions go from idle straight to the response state; allocate and free
// scan the table with the token, and a free that merges both neighbours adds a second shift step
// throughput: one item at a time, set by the scan token walking the cell chain
// one cell per cycle
// reset: table holds one free block from 0x8000 to 0xC000, registers at those values
// top level of the first-fit heap allocator
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int WW    = ADDR_BITS + 2;
    localparam logic [ADDR_BITS-1:0] HDR   = ADDR_BITS'(HEADER_BYTES);
    localparam logic [WW-1:0]        HDR_W = WW'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]     MAX_C = CNT_W'(MAX_BLOCKS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_MERGE2 = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0]           state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    out_item_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;
    logic [ADDR_BITS-1:0] heap_begin_reg, heap_end_reg;

    cell_cmd_t cmd;
    entry_t    ent [MAX_BLOCKS];
    logic      tok [MAX_BLOCKS];
    cell_rep_t rep [MAX_BLOCKS];
    cell_rep_t rep_or;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, heap_end_reg} : {16'd0, heap_begin_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_begin_reg <= HEAP_BEGIN_RST;
            heap_end_reg   <= HEAP_END_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                heap_end_reg <= pwdata[ADDR_BITS-1:0];
            end else begin
                heap_begin_reg <= pwdata[ADDR_BITS-1:0];
            end
        end
    end

    // cell chain
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        entry_t l_ent, r_ent;
        logic   l_tok, r_tok;
        if (g == 0) begin : g_first
            assign l_ent = '0;
            assign l_tok = 1'b0;
        end else begin : g_mid
            assign l_ent = ent[g-1];
            assign l_tok = tok[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_last
            assign r_ent = '0;
            assign r_tok = 1'b0;
        end else begin : g_body
            assign r_ent = ent[g+1];
            assign r_tok = tok[g+1];
        end
        ffha_cell #(
            .IS_HEAD (g == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .left_ent  (l_ent),
            .left_tok  (l_tok),
            .right_ent (r_ent),
            .right_tok (r_tok),
            .ent       (ent[g]),
            .tok       (tok[g]),
            .rep       (rep[g])
        );
    end

    always_comb begin
        rep_or = '0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            rep_or = rep_or | rep[k];
        end
    end

    // fit and merge arithmetic on the token cell
    logic [WW-1:0]        need_one, need_two, cur_size_w;
    logic [ADDR_BITS-1:0] cur_payload, sum_cn, sum_pc, sum_all;
    logic                 split_ok, whole_ok, match, next_m, prev_m;

    assign need_one    = WW'(item_reg.request_size) + HDR_W;
    assign need_two    = WW'(item_reg.request_size) + HDR_W + HDR_W;
    assign cur_size_w  = WW'(rep_or.cur.size);
    assign cur_payload = rep_or.cur.start + HDR;
    assign split_ok    = rep_or.cur.free && (cur_size_w > need_two) && (count_reg < MAX_C);
    assign whole_ok    = rep_or.cur.free && (cur_size_w >= need_one);
    assign match       = cur_payload == item_reg.block_address;
    assign next_m      = rep_or.next.valid && rep_or.next.free;
    assign prev_m      = rep_or.prev.valid && rep_or.prev.free;
    assign sum_cn      = rep_or.cur.size + rep_or.next.size;
    assign sum_pc      = rep_or.prev.size + rep_or.cur.size;
    assign sum_all     = sum_pc + rep_or.next.size;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        cmd          = '0;
        cmd.op       = OP_HOLD;
        s_ready      = (state_reg == S_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    res_next  = '0;
                    unique case (s_item.action) inside
                        ACT_ALLOC, ACT_FREE: begin
                            cmd.op     = OP_START;
                            state_next = S_SCAN;
                        end
                        ACT_INIT: begin
                            cmd.op         = OP_INIT;
                            cmd.wr_a.valid = 1'b1;
                            cmd.wr_a.free  = 1'b1;
                            cmd.wr_a.start = heap_begin_reg;
                            cmd.wr_a.size  = heap_end_reg - heap_begin_reg;
                            count_next     = CNT_W'(1);
                            state_next     = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!rep_or.hit) begin
                    res_next.result_address = '0;
                    res_next.status = (item_reg.action == ACT_ALLOC) ? STAT_OOM : STAT_UNKNOWN;
                    state_next = S_RESP;
                end else if (item_reg.action == ACT_ALLOC) begin
                    if (split_ok) begin
                        cmd.op         = OP_SPLIT;
                        cmd.wr_a       = rep_or.cur;
                        cmd.wr_a.free  = 1'b0;
                        cmd.wr_a.size  = need_one[ADDR_BITS-1:0];
                        cmd.wr_b.valid = 1'b1;
                        cmd.wr_b.free  = 1'b1;
                        cmd.wr_b.start = rep_or.cur.start + need_one[ADDR_BITS-1:0];
                        cmd.wr_b.size  = rep_or.cur.size - need_one[ADDR_BITS-1:0];
                        count_next     = count_reg + CNT_W'(1);
                        res_next.result_address = cur_payload;
                        res_next.status         = STAT_OK;
                        state_next     = S_RESP;
                    end else if (whole_ok) begin
                        cmd.op        = OP_SET_CUR;
                        cmd.wr_a      = rep_or.cur;
                        cmd.wr_a.free = 1'b0;
                        res_next.result_address = cur_payload;
                        res_next.status         = STAT_OK;
                        state_next    = S_RESP;
                    end else begin
                        cmd.op = OP_STEP;
                    end
                end else begin
                    if (match) begin
                        res_next   = '0;
                        state_next = S_RESP;
                        if (prev_m && next_m) begin
                            cmd.op        = OP_SET_PREV_SHL;
                            cmd.wr_a      = rep_or.prev;
                            cmd.wr_a.size = sum_all;
                            count_next    = count_reg - CNT_W'(2);
                            state_next    = S_MERGE2;
                        end else if (prev_m) begin
                            cmd.op        = OP_SET_PREV_SHL;
                            cmd.wr_a      = rep_or.prev;
                            cmd.wr_a.size = sum_pc;
                            count_next    = count_reg - CNT_W'(1);
                        end else if (next_m) begin
                            cmd.op        = OP_SET_CUR_SHL;
                            cmd.wr_a      = rep_or.cur;
                            cmd.wr_a.free = 1'b1;
                            cmd.wr_a.size = sum_cn;
                            count_next    = count_reg - CNT_W'(1);
                        end else begin
                            cmd.op        = OP_SET_CUR;
                            cmd.wr_a      = rep_or.cur;
                            cmd.wr_a.free = 1'b1;
                        end
                    end else begin
                        cmd.op = OP_STEP;
                    end
                end
            end
            S_MERGE2: begin
                cmd.op     = OP_SHL_GE;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    logic [MAX_BLOCKS-1:0] tok_vec;
    always_comb begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            tok_vec[k] = tok[k];
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(1)) && (count_reg <= MAX_C))
        else $error("entry count out of range");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one scan token");

    a_merge2_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE2) |=> (state_reg == S_RESP))
        else $error("double merge did not finish");

endmodule
